FILE: rtl/obfa_pkg.sv
// ----------------------------------------------------------------------------
// obfa_pkg
// Shared types and constants of the orthonormal basis pipeline.
// ----------------------------------------------------------------------------
package obfa_pkg;

  localparam int FIELD_W = 16;

  localparam int LANE_XX = 0;
  localparam int LANE_XZ = 1;
  localparam int LANE_ZZ = 2;

  localparam logic signed [FIELD_W-1:0] THRESH_RESET = -16'sd16383;

  typedef struct packed {
    logic signed [FIELD_W-1:0] axis_x;
    logic signed [FIELD_W-1:0] axis_y;
    logic signed [FIELD_W-1:0] axis_z;
  } axis_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] first_x;
    logic signed [FIELD_W-1:0] first_y;
    logic signed [FIELD_W-1:0] first_z;
    logic signed [FIELD_W-1:0] second_x;
    logic signed [FIELD_W-1:0] second_y;
    logic signed [FIELD_W-1:0] second_z;
    logic                      singular;
  } basis_t;

  typedef struct packed {
    logic valid;
    logic singular;
    logic neg;
  } ctl_t;

endpackage

FILE: rtl/obfa_prep.sv
// ----------------------------------------------------------------------------
// obfa_prep
// Two front stages: products, denominator and fallback test, then the
// rounded dividends 2|n|+d and the divisor 2d for the quotient pipeline.
// ----------------------------------------------------------------------------
module obfa_prep #(
  parameter int FRAC_BITS = 14,
  parameter int SW        = 18,
  parameter int CW        = 34
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  input  obfa_pkg::axis_t                        in_axis,
  input  logic signed [obfa_pkg::FIELD_W-1:0]    thresh,
  output obfa_pkg::ctl_t                         ctl_o,
  output logic signed [obfa_pkg::FIELD_W-1:0]    x_o,
  output logic signed [obfa_pkg::FIELD_W-1:0]    z_o,
  output logic [SW-1:0]                          den_o,
  output logic [2:0][CW-1:0]                     rem_o
);

  localparam logic signed [SW-1:0] ONE_S = SW'(1) << FRAC_BITS;

  logic                                 v1_r;
  logic                                 sing1_r;
  logic signed [obfa_pkg::FIELD_W-1:0]  x1_r, z1_r;
  logic signed [31:0]                   xx1_r, xz1_r, zz1_r;
  logic signed [SW-1:0]                 d1_r;

  logic signed [SW-1:0]                 d_nxt;
  logic                                 sing_nxt;
  logic signed [31:0]                   xx_nxt, xz_nxt, zz_nxt;

  obfa_pkg::ctl_t                       ctl2_r;
  logic signed [obfa_pkg::FIELD_W-1:0]  x2_r, z2_r;
  logic [SW-1:0]                        den2_r, den2_nxt;
  logic [2:0][CW-1:0]                   rem2_r, rem2_nxt;
  logic [31:0]                          mag_xz;

  always_comb begin
    d_nxt    = ONE_S + SW'(in_axis.axis_y);
    sing_nxt = (in_axis.axis_y < thresh) || d_nxt[SW-1] || (d_nxt == '0);
    xx_nxt   = in_axis.axis_x * in_axis.axis_x;
    xz_nxt   = in_axis.axis_x * in_axis.axis_z;
    zz_nxt   = in_axis.axis_z * in_axis.axis_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
    sing1_r <= sing_nxt;
    x1_r    <= in_axis.axis_x;
    z1_r    <= in_axis.axis_z;
    xx1_r   <= xx_nxt;
    xz1_r   <= xz_nxt;
    zz1_r   <= zz_nxt;
    d1_r    <= d_nxt;
  end

  always_comb begin
    mag_xz   = xz1_r[31] ? 32'(-xz1_r) : 32'(xz1_r);
    den2_nxt = {d1_r[SW-2:0], 1'b0};
    rem2_nxt[obfa_pkg::LANE_XX] = (CW'(32'(xx1_r)) << 1) + CW'(d1_r[SW-2:0]);
    rem2_nxt[obfa_pkg::LANE_XZ] = (CW'(mag_xz) << 1) + CW'(d1_r[SW-2:0]);
    rem2_nxt[obfa_pkg::LANE_ZZ] = (CW'(32'(zz1_r)) << 1) + CW'(d1_r[SW-2:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
    end else begin
      ctl2_r.valid    <= v1_r;
      ctl2_r.singular <= sing1_r;
      ctl2_r.neg      <= xz1_r[31];
    end
    x2_r   <= x1_r;
    z2_r   <= z1_r;
    den2_r <= den2_nxt;
    rem2_r <= rem2_nxt;
  end

  assign ctl_o = ctl2_r;
  assign x_o   = x2_r;
  assign z_o   = z2_r;
  assign den_o = den2_r;
  assign rem_o = rem2_r;

endmodule

FILE: rtl/obfa_div_step.sv
// ----------------------------------------------------------------------------
// obfa_div_step
// One restoring division stage: settles one quotient bit in each of the
// three lanes against the shared divisor.
// ----------------------------------------------------------------------------
module obfa_div_step #(
  parameter int SHIFT = 0,
  parameter int SW    = 18,
  parameter int CW    = 34,
  parameter int QW    = 17
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  obfa_pkg::ctl_t                      ctl_i,
  input  logic signed [obfa_pkg::FIELD_W-1:0] x_i,
  input  logic signed [obfa_pkg::FIELD_W-1:0] z_i,
  input  logic [SW-1:0]                       den_i,
  input  logic [2:0][CW-1:0]                  rem_i,
  input  logic [2:0][QW-1:0]                  quo_i,
  output obfa_pkg::ctl_t                      ctl_o,
  output logic signed [obfa_pkg::FIELD_W-1:0] x_o,
  output logic signed [obfa_pkg::FIELD_W-1:0] z_o,
  output logic [SW-1:0]                       den_o,
  output logic [2:0][CW-1:0]                  rem_o,
  output logic [2:0][QW-1:0]                  quo_o
);

  obfa_pkg::ctl_t                       ctl_r;
  logic signed [obfa_pkg::FIELD_W-1:0]  x_r, z_r;
  logic [SW-1:0]                        den_r;
  logic [2:0][CW-1:0]                   rem_r, rem_nxt;
  logic [2:0][QW-1:0]                   quo_r, quo_nxt;
  logic [CW-1:0]                        dsh;
  logic [2:0]                           ge;

  always_comb begin
    dsh = CW'(den_i) << SHIFT;
    for (int k = 0; k < 3; k++) begin
      ge[k]      = rem_i[k] >= dsh;
      rem_nxt[k] = ge[k] ? rem_i[k] - dsh : rem_i[k];
      quo_nxt[k] = {quo_i[k][QW-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
    x_r   <= x_i;
    z_r   <= z_i;
    den_r <= den_i;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign ctl_o = ctl_r;
  assign x_o   = x_r;
  assign z_o   = z_r;
  assign den_o = den_r;
  assign rem_o = rem_r;
  assign quo_o = quo_r;

endmodule

FILE: rtl/obfa_finish.sv
// ----------------------------------------------------------------------------
// obfa_finish
// Output stage: clamp quotients, form the basis components, saturate to
// plus or minus one and substitute the fallback frame.
// ----------------------------------------------------------------------------
module obfa_finish #(
  parameter int FRAC_BITS = 14,
  parameter int QW        = 17
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  obfa_pkg::ctl_t                      ctl_i,
  input  logic signed [obfa_pkg::FIELD_W-1:0] x_i,
  input  logic signed [obfa_pkg::FIELD_W-1:0] z_i,
  input  logic [2:0][QW-1:0]                  quo_i,
  output logic                                out_valid,
  output obfa_pkg::basis_t                    out_data
);

  localparam int EW = (FRAC_BITS + 4 > 18) ? FRAC_BITS + 4 : 18;
  localparam logic signed [EW-1:0] ONE_E = EW'(1) << FRAC_BITS;
  localparam logic signed [EW-1:0] NEG_ONE_E = -ONE_E;
  localparam logic [obfa_pkg::FIELD_W-1:0] NEG_ONE_F = NEG_ONE_E[obfa_pkg::FIELD_W-1:0];

  function automatic logic [obfa_pkg::FIELD_W-1:0] sat_unit(input logic signed [EW-1:0] v);
    logic signed [EW-1:0] c;
    c = v;
    if (v > ONE_E) begin
      c = ONE_E;
    end else if (v < -ONE_E) begin
      c = -ONE_E;
    end
    return c[obfa_pkg::FIELD_W-1:0];
  endfunction

  logic [2:0][QW-2:0]        qeff;
  logic signed [EW-1:0]      qs [3];
  logic signed [EW-1:0]      tv;
  obfa_pkg::basis_t          data_r, data_nxt;
  logic                      valid_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qeff[k] = quo_i[k][QW-1] ? '1 : quo_i[k][QW-2:0];
      qs[k]   = signed'(EW'(qeff[k]));
    end
    tv = ctl_i.neg ? qs[obfa_pkg::LANE_XZ] : -qs[obfa_pkg::LANE_XZ];
    if (ctl_i.singular) begin
      data_nxt          = '0;
      data_nxt.first_x  = NEG_ONE_F;
      data_nxt.second_z = NEG_ONE_F;
      data_nxt.singular = 1'b1;
    end else begin
      data_nxt.first_x  = sat_unit(ONE_E - qs[obfa_pkg::LANE_XX]);
      data_nxt.first_y  = sat_unit(-EW'(x_i));
      data_nxt.first_z  = sat_unit(tv);
      data_nxt.second_x = sat_unit(tv);
      data_nxt.second_y = sat_unit(-EW'(z_i));
      data_nxt.second_z = sat_unit(ONE_E - qs[obfa_pkg::LANE_ZZ]);
      data_nxt.singular = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl_i.valid;
    end
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

FILE: rtl/orthonormal_basis_from_axis.sv
// Throughput: one axis per cycle; busy stays low after reset, results are not held.
// The divider pipeline settles one quotient bit per stage, FRAC_BITS + 3 stages.
// Reset: synchronous, active low; clears all valid bits and loads the threshold
// register with its default; busy is high during reset and the cycle after.
// ----------------------------------------------------------------------------
// orthonormal_basis_from_axis
// Frisvad orthonormal frame from a unit axis in signed fixed point, with a
// configurable fallback threshold near y = -1.
// ----------------------------------------------------------------------------
module orthonormal_basis_from_axis #(
  parameter int FRAC_BITS = 14
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  obfa_pkg::axis_t                     in_data,
  output logic                                out_valid,
  output obfa_pkg::basis_t                    out_data,
  input  logic                                cfg_we,
  input  logic signed [obfa_pkg::FIELD_W-1:0] cfg_wdata
);

  localparam int SW  = ((FRAC_BITS > 16) ? FRAC_BITS : 16) + 2;
  localparam int QB  = FRAC_BITS + 2;
  localparam int QW  = QB + 1;
  localparam int CW  = (SW + QB > 34) ? SW + QB : 34;
  localparam int LAT = QW + 3;
  localparam logic [obfa_pkg::FIELD_W-1:0] NEG_ONE_F =
    obfa_pkg::FIELD_W'(0 - (1 << FRAC_BITS));

  logic                                 busy_r;
  logic signed [obfa_pkg::FIELD_W-1:0]  thresh_r;
  logic                                 accept;

  obfa_pkg::ctl_t                       ctl_s [QW+1];
  logic signed [obfa_pkg::FIELD_W-1:0]  x_s   [QW+1];
  logic signed [obfa_pkg::FIELD_W-1:0]  z_s   [QW+1];
  logic [SW-1:0]                        den_s [QW+1];
  logic [2:0][CW-1:0]                   rem_s [QW+1];
  logic [2:0][QW-1:0]                   quo_s [QW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b1;
      thresh_r <= obfa_pkg::THRESH_RESET;
    end else begin
      busy_r <= 1'b0;
      if (cfg_we) begin
        thresh_r <= cfg_wdata;
      end
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  obfa_prep #(
    .FRAC_BITS (FRAC_BITS),
    .SW        (SW),
    .CW        (CW)
  ) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (accept),
    .in_axis  (in_data),
    .thresh   (thresh_r),
    .ctl_o    (ctl_s[0]),
    .x_o      (x_s[0]),
    .z_o      (z_s[0]),
    .den_o    (den_s[0]),
    .rem_o    (rem_s[0])
  );

  assign quo_s[0] = '0;

  for (genvar i = 0; i < QW; i++) begin : g_div
    obfa_div_step #(
      .SHIFT (QB - i),
      .SW    (SW),
      .CW    (CW),
      .QW    (QW)
    ) u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (ctl_s[i]),
      .x_i   (x_s[i]),
      .z_i   (z_s[i]),
      .den_i (den_s[i]),
      .rem_i (rem_s[i]),
      .quo_i (quo_s[i]),
      .ctl_o (ctl_s[i+1]),
      .x_o   (x_s[i+1]),
      .z_o   (z_s[i+1]),
      .den_o (den_s[i+1]),
      .rem_o (rem_s[i+1]),
      .quo_o (quo_s[i+1])
    );
  end

  obfa_finish #(
    .FRAC_BITS (FRAC_BITS),
    .QW        (QW)
  ) u_finish (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_i     (ctl_s[QW]),
    .x_i       (x_s[QW]),
    .z_i       (z_s[QW]),
    .quo_i     (quo_s[QW]),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_valid)
    else $error("transaction did not reach the output after the pipeline latency");

  a_latency_bwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result without a matching input transaction");

  a_fallback: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.singular |->
      out_data.first_x == NEG_ONE_F && out_data.second_z == NEG_ONE_F &&
      out_data.first_y == '0 && out_data.first_z == '0 &&
      out_data.second_x == '0 && out_data.second_y == '0)
    else $error("fallback frame corrupted");

  a_shared_term: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.singular |-> out_data.first_z == out_data.second_x)
    else $error("common term differs between basis vectors");
`endif

endmodule

FILE: tb/sv/obfa_frame_checker.sv
// ----------------------------------------------------------------------------
// obfa_frame_checker
// Watches the axis and basis channels of orthonormal_basis_from_axis. For each
// accepted axis it builds the expected Frisvad frame from its own copy of the
// fallback threshold, queues it and compares every result field by field with
// the oldest queued frame. Mismatches and the pending count go to the top.
// ----------------------------------------------------------------------------
module obfa_frame_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                busy,
  input  obfa_pkg::axis_t                     in_data,
  input  logic                                out_valid,
  input  obfa_pkg::basis_t                    out_data,
  input  logic                                cfg_we,
  input  logic signed [obfa_pkg::FIELD_W-1:0] cfg_wdata,
  output int unsigned                         mismatch_count,
  output int unsigned                         frames_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FW = obfa_pkg::FIELD_W;
  localparam longint UNIT = longint'(1) << 14;

  logic signed [FW-1:0]      threshold = obfa_pkg::THRESH_RESET;
  obfa_pkg::basis_t          frames_due[$];
  obfa_pkg::basis_t          want;
  int unsigned               errors = 0;

  assign mismatch_count = errors;

  function automatic longint clamp_unit(longint v);
    if (v > UNIT) return UNIT;
    if (v < -UNIT) return -UNIT;
    return v;
  endfunction

  // nearest, ties away from zero; den is positive
  function automatic longint quotient_rounded(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (2 * mag + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  function automatic obfa_pkg::basis_t frisvad_frame(obfa_pkg::axis_t a,
                                                     logic signed [FW-1:0] thr);
    longint x;
    longint y;
    longint z;
    longint den;
    longint t;
    obfa_pkg::basis_t f;
    x = $signed(a.axis_x);
    y = $signed(a.axis_y);
    z = $signed(a.axis_z);
    den = UNIT + y;
    f = '0;
    if (y < longint'($signed(thr)) || den <= 0) begin
      f.first_x = FW'(-UNIT);
      f.second_z = FW'(-UNIT);
      f.singular = 1'b1;
    end else begin
      t = clamp_unit(-quotient_rounded(x * z, den));
      f.first_x = FW'(clamp_unit(UNIT - quotient_rounded(x * x, den)));
      f.first_y = FW'(clamp_unit(-x));
      f.first_z = FW'(t);
      f.second_x = FW'(t);
      f.second_y = FW'(clamp_unit(-z));
      f.second_z = FW'(clamp_unit(UNIT - quotient_rounded(z * z, den)));
      f.singular = 1'b0;
    end
    return f;
  endfunction

  task automatic compare_field(string name, logic signed [FW-1:0] exp_v,
                               logic signed [FW-1:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      frames_due.delete();
      threshold <= obfa_pkg::THRESH_RESET;
      frames_pending <= 0;
    end else begin
      if (out_valid) begin
        if (frames_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, out_data);
          errors++;
        end else begin
          want = frames_due.pop_front();
          compare_field("first_x", want.first_x, out_data.first_x);
          compare_field("first_y", want.first_y, out_data.first_y);
          compare_field("first_z", want.first_z, out_data.first_z);
          compare_field("second_x", want.second_x, out_data.second_x);
          compare_field("second_y", want.second_y, out_data.second_y);
          compare_field("second_z", want.second_z, out_data.second_z);
          compare_field("singular", {15'd0, want.singular}, {15'd0, out_data.singular});
        end
      end
      if (start && !busy) frames_due.push_back(frisvad_frame(in_data, threshold));
      if (cfg_we) threshold <= cfg_wdata;
      frames_pending <= frames_due.size();
    end
  end

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives orthonormal_basis_from_axis with directed axes (unit axes, y near -1,
// rounding ties, saturating and unnormalized inputs) and then random axes over
// a sweep of fallback thresholds, with random gaps and bursts. The checker
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FW          = obfa_pkg::FIELD_W;
  localparam int FRAC        = 14;
  localparam int UNIT        = 1 << FRAC;
  localparam int LATENCY     = FRAC + 6;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 250;
  localparam int PHASES      = 7;
  localparam int SWEEP[PHASES] = '{-16384, 16384, -8192, -16300, 0, 0, -16383};

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  obfa_pkg::axis_t           in_data = '0;
  logic                      out_valid;
  obfa_pkg::basis_t          out_data;
  logic                      cfg_we = 1'b0;
  logic signed [FW-1:0]      cfg_wdata = '0;
  int unsigned               mismatch_count;
  int unsigned               frames_pending;
  int unsigned               idle_cycles = 0;
  int                        burst_left = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  orthonormal_basis_from_axis #(.FRAC_BITS(FRAC)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  obfa_frame_checker frame_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .mismatch_count(mismatch_count),
    .frames_pending(frames_pending)
  );

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic obfa_pkg::axis_t axis_of(int x, int y, int z);
    obfa_pkg::axis_t a;
    a.axis_x = FW'(x);
    a.axis_y = FW'(y);
    a.axis_z = FW'(z);
    return a;
  endfunction

  function automatic obfa_pkg::axis_t random_axis();
    int  kind;
    int  x;
    int  y;
    int  z;
    int  lim;
    real rem;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      x = $urandom_range(0, 2 * UNIT) - UNIT;
      rem = $itor(UNIT) * $itor(UNIT) - $itor(x) * $itor(x);
      lim = $rtoi($sqrt(rem));
      z = $urandom_range(0, 2 * lim) - lim;
      rem = rem - $itor(z) * $itor(z);
      if (rem < 0.0) rem = 0.0;
      y = $rtoi($sqrt(rem) + 0.5);
      if ($urandom_range(0, 1)) y = -y;
    end else if (kind < 75) begin
      x = $urandom_range(0, 512) - 256;
      y = $urandom_range(0, 64) - UNIT;
      z = $urandom_range(0, 512) - 256;
    end else if (kind < 90) begin
      x = $urandom_range(0, 2 * UNIT) - UNIT;
      y = $urandom_range(0, 2 * UNIT) - UNIT;
      z = $urandom_range(0, 2 * UNIT) - UNIT;
    end else begin
      x = $urandom;
      y = $urandom;
      z = $urandom;
    end
    return axis_of(x, y, z);
  endfunction

  task automatic send_axis(obfa_pkg::axis_t a);
    int gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(16, 64);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= a;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (frames_pending != 0);
  endtask

  task automatic write_threshold(logic signed [FW-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int p;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_axis(axis_of(0, UNIT, 0));
    send_axis(axis_of(0, -UNIT, 0));
    send_axis(axis_of(0, -UNIT + 1, 0));
    send_axis(axis_of(UNIT, 0, 0));
    send_axis(axis_of(-UNIT, 0, 0));
    send_axis(axis_of(0, 0, UNIT));
    send_axis(axis_of(0, 0, -UNIT));
    send_axis(axis_of(11585, 0, 11585));
    send_axis(axis_of(-11585, 0, 11585));
    send_axis(axis_of(9459, 9459, 9459));
    send_axis(axis_of(9459, -9459, -9459));
    send_axis(axis_of(1, -UNIT + 2, 1));
    send_axis(axis_of(-1, -UNIT + 2, 1));
    send_axis(axis_of(1, -UNIT + 1, 1));
    send_axis(axis_of(128, -UNIT + 1, -128));
    send_axis(axis_of(32767, 0, 32767));
    send_axis(axis_of(-32768, 0, -32768));
    send_axis(axis_of(32767, -16000, -32768));
    send_axis(axis_of(0, 32767, 0));
    send_axis(axis_of(100, -32768, 100));
    send_axis(axis_of(-32768, 32767, 32767));

    write_threshold(-16'sd16384);
    send_axis(axis_of(0, -UNIT, 0));
    send_axis(axis_of(5, -UNIT, 7));

    for (p = 0; p < PHASES; p++) begin
      if (p == 4) write_threshold(FW'($urandom_range(0, 2 * UNIT) - UNIT));
      else write_threshold(FW'(SWEEP[p]));
      repeat (PHASE_ITEMS) send_axis(random_axis());
    end

    drain();
    repeat (LATENCY + 5) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
